[sv/ita_pkg.sv]
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types and constants of the integer to ASCII formatter: request and
// result payloads, command codes, character constants, controller commands.
// ----------------------------------------------------------------------------
package ita_pkg;

	// Request payload
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] value;
		logic [3:0]  width;
	} in_item_t;

	// Result payload, one character per result
	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} out_item_t;

	// Command codes
	localparam logic [2:0] CMD_CHAR      = 3'd0;
	localparam logic [2:0] CMD_OCT       = 3'd1;
	localparam logic [2:0] CMD_HEX       = 3'd2;
	localparam logic [2:0] CMD_SDEC_LIM  = 3'd3;
	localparam logic [2:0] CMD_SDEC_FULL = 3'd4;
	localparam logic [2:0] CMD_UDEC      = 3'd5;

	// Digit store depth in nibbles and the character cap of limited modes
	localparam int         DIGITS    = 11;
	localparam logic [3:0] WIDTH_CAP = 4'd11;

	// Characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Source of an output character
	typedef enum logic [1:0] {
		SEL_CHAR,
		SEL_SIGN,
		SEL_DIGIT
	} out_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;      // capture request, form magnitude
		logic     step;      // one double-dabble step
		logic     split;     // fill digit store from magnitude bits
		logic     split_hex; // 1 hex digits, 0 octal digits
		logic     shift;     // drop top digit
		logic     out_load;  // load result register
		out_sel_t out_sel;
		logic     out_last;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic neg;      // request is negative
		logic top_zero; // top digit of store is zero
		logic rem_one;  // one digit left in store
	} dp_stat_t;

endpackage

[sv/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one request (command, value, width) into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready take one request: cmd, value, width. The block
//   answers with res_valid/res_ready, one character per request result,
//   most significant first, res_data.last marking the final character.
//   Char mode returns the low byte; octal, hex and signed decimal print '-'
//   if negative, then the magnitude; limited modes keep only the first width
//   characters; width 0 in a limited mode or an unused command gives nothing.
// Timing:
//   Decimal modes run a double-dabble converter over every magnitude bit,
//   one bit a cycle; octal and hex split the magnitude into digits directly.
//   Leading zeros are then dropped one per cycle, and characters leave one
//   per cycle while the receiver takes them. One request is in work at a
//   time; req_ready is high only between requests, while the result register
//   holds the last char. A stalled receiver holds the sequencer; nothing is
//   dropped. Reset clears the sequencer and the result valid; no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ita_pkg::in_item_t   req_data,
	output logic                res_valid,
	input  logic                res_ready,
	output ita_pkg::out_item_t  res_data
);
	import ita_pkg::*;

	localparam int MW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer
	ita_ctrl #(
		.MAG_BITS (MW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req_data.cmd),
		.req_width (req_data.width),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	// Conversion datapath
	ita_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.res_data (res_data)
	);

endmodule

[sv/ita_datapath.sv]
// ----------------------------------------------------------------------------
// ita_datapath
// Magnitude register, double-dabble BCD converter, digit store shifted out
// most significant first, and the result register.
// ----------------------------------------------------------------------------
module ita_datapath #(
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ita_pkg::in_item_t   req_data,
	input  ita_pkg::dp_cmd_t    cmd,
	output ita_pkg::dp_stat_t   stat,
	output ita_pkg::out_item_t  res_data
);
	import ita_pkg::*;

	// Magnitude width; above 32 bits the sign bit is never set
	localparam int  MW        = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam bit  SIGNED_OK = (VALUE_BITS <= 32);
	localparam int  SW        = 4 * DIGITS;

	logic [MW-1:0] mag_q;
	logic          neg_q;
	logic [SW-1:0] dig_q;
	logic [3:0]    rem_q;
	out_item_t     res_q;

	logic [MW-1:0] v;
	logic          signed_mode;
	logic          neg_now;
	logic [SW-1:0] dig_adj;
	logic [SW-1:0] magx;
	logic [SW-1:0] dig_split;
	logic [3:0]    top;
	logic [7:0]    digit_char;
	logic [7:0]    out_char;

	// Request decode: sign and magnitude
	assign v           = req_data.value[MW-1:0];
	assign signed_mode = SIGNED_OK && (req_data.cmd == CMD_OCT || req_data.cmd == CMD_HEX ||
		req_data.cmd == CMD_SDEC_LIM || req_data.cmd == CMD_SDEC_FULL);
	assign neg_now     = signed_mode && v[MW-1];

	// Double-dabble add-3 correction, one per digit
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			end else begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4];
			end
		end
	end

	// Octal and hex digits come straight from the magnitude bits
	assign magx = SW'(mag_q);
	always_comb begin
		dig_split = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (cmd.split_hex) begin
				if (4*i + 4 <= SW) begin
					dig_split[4*i +: 4] = magx[4*i +: 4];
				end
			end else begin
				dig_split[4*i +: 4] = {1'b0, magx[3*i +: 3]};
			end
		end
	end

	// Character of the top digit
	assign top = dig_q[SW-1 -: 4];
	always_comb begin
		if (top < 4'd10) begin
			digit_char = CH_ZERO + {4'b0, top};
		end else begin
			digit_char = CH_A + {4'b0, top - 4'd10};
		end
	end

	always_comb begin
		unique case (cmd.out_sel)
			SEL_CHAR:  out_char = mag_q[7:0];
			SEL_SIGN:  out_char = CH_MINUS;
			SEL_DIGIT: out_char = digit_char;
			default:   out_char = digit_char;
		endcase
	end

	// Magnitude and digit store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			rem_q <= 4'd0;
		end else begin
			if (cmd.load) begin
				neg_q <= neg_now;
				rem_q <= 4'(DIGITS);
			end else if (cmd.shift) begin
				rem_q <= rem_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= neg_now ? (~v + MW'(1)) : v;
			dig_q <= '0;
		end else if (cmd.step) begin
			dig_q <= {dig_adj[SW-2:0], mag_q[MW-1]};
			mag_q <= mag_q << 1;
		end else if (cmd.split) begin
			dig_q <= dig_split;
		end else if (cmd.shift) begin
			dig_q <= dig_q << 4;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.char_code <= out_char;
			res_q.last      <= cmd.out_last;
		end
	end

	assign res_data      = res_q;
	assign stat.neg      = neg_q;
	assign stat.top_zero = (top == 4'd0);
	assign stat.rem_one  = (rem_q == 4'd1);

endmodule

[sv/ita_ctrl.sv]
// ----------------------------------------------------------------------------
// ita_ctrl
// Sequencer of the formatter: request decode, conversion step count,
// leading-zero skip, character count limit and result handshake.
// ----------------------------------------------------------------------------
module ita_ctrl #(
	parameter int MAG_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [2:0]         req_cmd,
	input  logic [3:0]         req_width,
	output logic               res_valid,
	input  logic               res_ready,
	output ita_pkg::dp_cmd_t   cmd,
	input  ita_pkg::dp_stat_t  stat
);
	import ita_pkg::*;

	localparam int CW = $clog2(MAG_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR,
		ST_SPLIT,
		ST_DABBLE,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]  lim_q;
	logic        limited_q;
	logic        hex_q;
	logic        res_valid_q;

	logic        out_free;
	logic        lim_last;
	logic        digit_last;
	logic [3:0]  width_cap;

	assign out_free   = !res_valid_q || res_ready;
	assign lim_last   = limited_q && (lim_q == 4'd1);
	assign digit_last = stat.rem_one || lim_last;
	assign width_cap  = (req_width > WIDTH_CAP) ? WIDTH_CAP : req_width;
	assign req_ready  = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;

	// Datapath commands
	always_comb begin
		cmd           = '0;
		cmd.out_sel   = SEL_DIGIT;
		cmd.split_hex = hex_q;
		unique case (state_q)
			ST_IDLE:   cmd.load = req_valid;
			ST_CHAR: begin
				cmd.out_load = out_free;
				cmd.out_sel  = SEL_CHAR;
				cmd.out_last = 1'b1;
			end
			ST_SPLIT:  cmd.split = 1'b1;
			ST_DABBLE: cmd.step = 1'b1;
			ST_SIGN: begin
				cmd.out_load = out_free;
				cmd.out_sel  = SEL_SIGN;
				cmd.out_last = lim_last;
			end
			ST_SKIP:   cmd.shift = stat.top_zero && !stat.rem_one;
			ST_EMIT: begin
				cmd.out_load = out_free;
				cmd.shift    = out_free;
				cmd.out_last = digit_last;
			end
			default: ;
		endcase
	end

	// State, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lim_q       <= 4'd0;
			limited_q   <= 1'b0;
			hex_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						lim_q     <= width_cap;
						limited_q <= (req_cmd != CMD_SDEC_FULL);
						hex_q     <= (req_cmd == CMD_HEX);
						cnt_q     <= CW'(MAG_BITS);
						priority case (req_cmd)
							CMD_CHAR: state_q <= ST_CHAR;
							CMD_OCT, CMD_HEX: begin
								if (req_width != 4'd0) state_q <= ST_SPLIT;
							end
							CMD_SDEC_LIM, CMD_UDEC: begin
								if (req_width != 4'd0) state_q <= ST_DABBLE;
							end
							CMD_SDEC_FULL: state_q <= ST_DABBLE;
							default: ;
						endcase
					end
				end
				ST_CHAR: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_SPLIT: begin
					state_q <= stat.neg ? ST_SIGN : ST_SKIP;
				end
				ST_DABBLE: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= stat.neg ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						lim_q   <= lim_q - 4'd1;
						state_q <= lim_last ? ST_IDLE : ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!stat.top_zero || stat.rem_one) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						lim_q <= lim_q - 4'd1;
						if (digit_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
